// ----- hw/rtl/lsfs_pkg.sv -----
package lsfs_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_START = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_e;

  localparam logic [7:0] REG_BRIGHTNESS = 8'd0;
  localparam logic [7:0] REG_ONE_DUTY   = 8'd1;
  localparam logic [7:0] REG_ZERO_DUTY  = 8'd2;
  localparam logic [7:0] REG_LATCH      = 8'd3;

  localparam logic [6:0]  BRIGHTNESS_RESET = 7'd40;
  localparam logic [15:0] ONE_DUTY_RESET   = 16'd65;
  localparam logic [15:0] ZERO_DUTY_RESET  = 16'd30;
  localparam logic [7:0]  LATCH_RESET      = 8'd60;
  localparam logic [6:0]  FULL_SCALE       = 7'd100;

  localparam int unsigned BITS_PER_LED = 24;
  localparam logic [4:0]  TOP_BIT      = 5'(BITS_PER_LED - 1);

  // x / 100 equals (x * 5243) >> 19 for every x below 43690.
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] led_index;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } cmd_t;

  typedef struct packed {
    logic [15:0] duty_code;
    logic        last_slot;
  } res_t;

endpackage

// ----- hw/rtl/led_strip_frame_serializer.sv -----
// Write, clear and start commands, and ticks outside a frame, keep busy low.
// A tick on the first bit of an LED holds busy through one color read, then three
// channels, each a multiply by brightness and a reciprocal multiply on one shared
// multiplier, and then the emit state; the strobe follows in the cycle after. Any other
// tick in a frame goes straight to emit. Results cannot be stalled. Reset clears all colors
// to zero and loads the defaults: brightness 40, one duty 65, zero duty 30, 60 latch slots.
module led_strip_frame_serializer #(
  parameter int unsigned LED_COUNT = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  lsfs_pkg::cmd_t cmd_i,
  output logic          out_strobe_o,
  output lsfs_pkg::res_t res_o,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_index_i,
  input  logic [15:0]   cfg_wdata_i
);
  import lsfs_pkg::*;

  localparam int unsigned LedW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [LedW-1:0] LAST_LED = LedW'(LED_COUNT - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [6:0]  bright_q;
  logic [15:0] one_q, zero_q;
  logic [7:0]  latch_q;
  logic        frame_q, data_phase_q;
  logic [LedW-1:0] led_q;
  logic [4:0]  bit_q;
  logic [7:0]  latch_cnt_q;
  logic [1:0]  ch_q;
  logic [14:0] prod_q;
  logic [23:0] grb_q, color_q;
  logic        strobe_q;
  res_t        res_q;

  logic        accept;
  logic        mem_we;
  logic        mem_clear;
  logic [23:0] mem_rdata;
  logic [15:0] mul_a;
  logic [12:0] mul_b;
  logic [28:0] mul_p;
  logic [7:0]  chan;
  logic        last;
  logic [15:0] duty;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  assign mem_we    = accept && !frame_q && (cmd_i.command == CMD_WRITE)
                     && ({1'b0, cmd_i.led_index} < 9'(LED_COUNT));
  assign mem_clear = accept && !frame_q && (cmd_i.command == CMD_CLEAR);

  lsfs_color_mem #(
    .Depth(LED_COUNT),
    .AddrW(LedW)
  ) u_color_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (cmd_i.led_index[LedW-1:0]),
    .wdata_i ({cmd_i.red_level, cmd_i.green_level, cmd_i.blue_level}),
    .clear_i (mem_clear),
    .raddr_i (led_q),
    .rdata_o (mem_rdata)
  );

  // Channels are taken in green, red, blue order so the word shifts in as GRB.
  always_comb begin
    case (ch_q)
      2'd0:    chan = color_q[15:8];
      2'd1:    chan = color_q[23:16];
      default: chan = color_q[7:0];
    endcase
  end

  // The one multiplier: level times brightness, then that product times 1/100.
  always_comb begin
    if (state_q == S_DIV) begin
      mul_a = {1'b0, prod_q};
      mul_b = RECIP_100;
    end else begin
      mul_a = {8'd0, chan};
      mul_b = {6'd0, bright_q};
    end
  end
  assign mul_p = 29'(mul_a * mul_b);

  always_comb begin
    if (data_phase_q) begin
      last = (latch_q == 8'd0) && (led_q == LAST_LED) && (bit_q == 5'd0);
      duty = grb_q[bit_q] ? one_q : zero_q;
    end else begin
      last = (latch_cnt_q + 8'd1 == latch_q);
      duty = 16'd0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && frame_q && (cmd_i.command == CMD_TICK)) begin
          state_d = (data_phase_q && (bit_q == TOP_BIT)) ? S_FETCH : S_EMIT;
        end
      end
      S_FETCH: state_d = S_MUL;
      S_MUL:   state_d = S_DIV;
      S_DIV:   state_d = (ch_q == 2'd2) ? S_EMIT : S_MUL;
      S_EMIT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      bright_q     <= BRIGHTNESS_RESET;
      one_q        <= ONE_DUTY_RESET;
      zero_q       <= ZERO_DUTY_RESET;
      latch_q      <= LATCH_RESET;
      frame_q      <= 1'b0;
      data_phase_q <= 1'b1;
      led_q        <= '0;
      bit_q        <= TOP_BIT;
      latch_cnt_q  <= 8'd0;
      ch_q         <= 2'd0;
      grb_q        <= 24'd0;
      strobe_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= (state_q == S_EMIT);

      if (cfg_we_i && !frame_q) begin
        case (cfg_index_i)
          REG_BRIGHTNESS: bright_q <= (cfg_wdata_i[6:0] > FULL_SCALE) ? FULL_SCALE
                                                                      : cfg_wdata_i[6:0];
          REG_ONE_DUTY:   one_q    <= cfg_wdata_i;
          REG_ZERO_DUTY:  zero_q   <= cfg_wdata_i;
          REG_LATCH:      latch_q  <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end

      if (accept && !frame_q && (cmd_i.command == CMD_START)) begin
        frame_q      <= 1'b1;
        data_phase_q <= 1'b1;
        led_q        <= '0;
        bit_q        <= TOP_BIT;
        latch_cnt_q  <= 8'd0;
      end

      case (state_q)
        S_FETCH: ch_q <= 2'd0;
        S_DIV: begin
          grb_q <= {grb_q[15:0], mul_p[RECIP_SHIFT+7:RECIP_SHIFT]};
          ch_q  <= ch_q + 2'd1;
        end
        S_EMIT: begin
          if (last) begin
            frame_q      <= 1'b0;
            data_phase_q <= 1'b1;
            led_q        <= '0;
            bit_q        <= TOP_BIT;
            latch_cnt_q  <= 8'd0;
          end else if (data_phase_q) begin
            if (bit_q == 5'd0) begin
              bit_q <= TOP_BIT;
              if (led_q == LAST_LED) begin
                data_phase_q <= 1'b0;
                led_q        <= '0;
              end else begin
                led_q <= led_q + LedW'(1);
              end
            end else begin
              bit_q <= bit_q - 5'd1;
            end
          end else begin
            latch_cnt_q <= latch_cnt_q + 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FETCH) begin
      color_q <= mem_rdata;
    end
    if (state_q == S_MUL) begin
      prod_q <= mul_p[14:0];
    end
    if (state_q == S_EMIT) begin
      res_q.duty_code <= duty;
      res_q.last_slot <= last;
    end
  end

  assign out_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

// ----- hw/rtl/lsfs_color_mem.sv -----
module lsfs_color_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [23:0]      wdata_i,
  input  logic             clear_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [23:0]      rdata_o
);

  logic [23:0]      mem_q [Depth];
  logic [Depth-1:0] valid_q;
  logic [23:0]      rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  // An entry that was never written since reset or the last clear reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (clear_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : 24'd0;

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsfs_pkg::*;

  localparam int unsigned LEDS           = 64;
  localparam int unsigned DATA_SLOTS     = LEDS * BITS_PER_LED;
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  cmd_t        cmd_i;
  logic        out_strobe_o;
  res_t        res_o;
  logic        cfg_we_i;
  logic [7:0]  cfg_index_i;
  logic [15:0] cfg_wdata_i;

  led_strip_frame_serializer #(
    .LED_COUNT(LEDS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .out_strobe_o(out_strobe_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow of the strip state and the registers.
  logic [23:0] color_mem [LEDS];
  bit          frame_on;
  int unsigned slot_pos;
  logic [23:0] grb_word;
  int unsigned bright_pct;
  logic [15:0] one_duty;
  logic [15:0] zero_duty;
  logic [7:0]  latch_len;

  res_t        pending_slots [$];
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  bit          gaps_on;

  function automatic void reset_strip_model();
    foreach (color_mem[i]) color_mem[i] = '0;
    frame_on   = 1'b0;
    slot_pos   = 0;
    grb_word   = '0;
    bright_pct = BRIGHTNESS_RESET;
    one_duty   = ONE_DUTY_RESET;
    zero_duty  = ZERO_DUTY_RESET;
    latch_len  = LATCH_RESET;
  endfunction

  function automatic logic [7:0] dim_level(logic [7:0] level);
    return 8'((int'(level) * bright_pct) / FULL_SCALE);
  endfunction

  function automatic void apply_reg(logic [7:0] idx, logic [15:0] data);
    if (frame_on) return;
    case (idx)
      REG_BRIGHTNESS: bright_pct = (data[6:0] > FULL_SCALE) ? FULL_SCALE : data[6:0];
      REG_ONE_DUTY:   one_duty   = data;
      REG_ZERO_DUTY:  zero_duty  = data;
      REG_LATCH:      latch_len  = data[7:0];
      default: ;
    endcase
  endfunction

  // Advances the shadow state by one accepted item and queues the slot, if any, that it produces.
  function automatic void serialize_cmd(cmd_t c);
    int unsigned led;
    int unsigned bpos;
    int unsigned total;
    res_t        r;
    total = DATA_SLOTS + latch_len;
    if (c.command != CMD_TICK) begin
      if (frame_on) return;
      case (c.command)
        CMD_WRITE: begin
          if (c.led_index < LEDS)
            color_mem[c.led_index] = {c.red_level, c.green_level, c.blue_level};
        end
        CMD_CLEAR: begin
          foreach (color_mem[i]) color_mem[i] = '0;
        end
        default: begin
          frame_on = 1'b1;
          slot_pos = 0;
        end
      endcase
      return;
    end
    if (!frame_on) return;
    if (slot_pos < DATA_SLOTS) begin
      led  = slot_pos / BITS_PER_LED;
      bpos = BITS_PER_LED - 1 - slot_pos % BITS_PER_LED;
      if (bpos == BITS_PER_LED - 1)
        grb_word = {dim_level(color_mem[led][15:8]), dim_level(color_mem[led][23:16]),
                    dim_level(color_mem[led][7:0])};
      r.duty_code = grb_word[bpos] ? one_duty : zero_duty;
    end else begin
      r.duty_code = '0;
    end
    r.last_slot = (slot_pos + 1 >= total);
    pending_slots.push_back(r);
    if (r.last_slot) begin
      frame_on = 1'b0;
      slot_pos = 0;
    end else begin
      slot_pos++;
    end
  endfunction

  task automatic flag_mismatch(string what);
    $display("ERROR %0d ns: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : check_slots
    res_t want;
    if (rst_ni && out_strobe_o) begin
      if (pending_slots.size() == 0) begin
        flag_mismatch($sformatf("slot duty %0d last %0b with none expected",
                                res_o.duty_code, res_o.last_slot));
      end else begin
        want = pending_slots.pop_front();
        if (res_o.duty_code !== want.duty_code)
          flag_mismatch($sformatf("duty_code %0d, expected %0d",
                                  res_o.duty_code, want.duty_code));
        if (res_o.last_slot !== want.last_slot)
          flag_mismatch($sformatf("last_slot %0b, expected %0b",
                                  res_o.last_slot, want.last_slot));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || out_strobe_o || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("led_strip_frame_serializer: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic cmd_t pack_cmd(cmd_e op, logic [7:0] idx, logic [7:0] r,
                                    logic [7:0] g, logic [7:0] b);
    cmd_t c;
    c.command     = op;
    c.led_index   = idx;
    c.red_level   = r;
    c.green_level = g;
    c.blue_level  = b;
    return c;
  endfunction

  function automatic cmd_t random_cmd(cmd_e op);
    return pack_cmd(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endfunction

  // Called right after a rising edge; returns right after the edge that took the item.
  task automatic send_item(cmd_t c);
    int unsigned gap;
    if ($urandom_range(0, 49) == 0) gaps_on = !gaps_on;
    gap = gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    serialize_cmd(c);
  endtask

  // Stops sending and waits until the block has nothing left in flight.
  task automatic settle();
    start <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The enable stays high across back-to-back writes; end_writes drops it.
  task automatic write_reg(logic [7:0] idx, logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    apply_reg(idx, data);
  endtask

  task automatic end_writes();
    cfg_we_i <= 1'b0;
  endtask

  // Ticks until the frame ends; noise_pct of the items are commands the frame must ignore.
  task automatic finish_frame(int unsigned noise_pct);
    while (frame_on) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_item(random_cmd(cmd_e'($urandom_range(0, 2))));
      else
        send_item(random_cmd(CMD_TICK));
    end
  endtask

  task automatic test_directed();
    send_item(pack_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(pack_cmd(CMD_WRITE, 8'd0, 8'hFF, 8'hFF, 8'hFF));
    send_item(pack_cmd(CMD_WRITE, 8'd63, 8'h80, 8'h01, 8'hFF));
    send_item(pack_cmd(CMD_WRITE, 8'd64, 8'hFF, 8'hFF, 8'hFF));
    send_item(pack_cmd(CMD_WRITE, 8'd255, 8'hFF, 8'hFF, 8'hFF));
    send_item(pack_cmd(CMD_WRITE, 8'd7, 8'hAA, 8'h55, 8'h0F));
    send_item(pack_cmd(CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(pack_cmd(CMD_WRITE, 8'd0, 8'hFF, 8'h00, 8'h7F));
    send_item(pack_cmd(CMD_WRITE, 8'd1, 8'h00, 8'hFF, 8'h01));
    send_item(pack_cmd(CMD_WRITE, 8'd32, 8'h64, 8'hC8, 8'h19));
    send_item(pack_cmd(CMD_WRITE, 8'd63, 8'hFF, 8'hFF, 8'hFF));
  endtask

  // The brightness write has 101 in its low seven bits, so it is held at 100.
  // The latch count keeps its reset value.
  task automatic test_reg_writes();
    settle();
    write_reg(REG_BRIGHTNESS, 16'h00E5);
    write_reg(REG_ONE_DUTY, 16'($urandom_range(0, 65535)));
    write_reg(REG_ZERO_DUTY, 16'($urandom_range(0, 65535)));
    // An index past the last register must leave everything alone.
    write_reg(8'($urandom_range(4, 255)), 16'($urandom_range(0, 65535)));
    write_reg(8'hFF, 16'hFFFF);
    end_writes();
  endtask

  // Loads colors at random, with a clear or an idle tick now and then.
  task automatic test_loads(int unsigned n_loads);
    int unsigned pick;
    cmd_t        c;
    repeat (n_loads) begin
      pick = $urandom_range(0, 99);
      if (pick < 84) begin
        c = random_cmd(CMD_WRITE);
        if ($urandom_range(0, 99) < 85) c.led_index = 8'($urandom_range(0, LEDS - 1));
        send_item(c);
      end else if (pick < 88) begin
        send_item(random_cmd(CMD_CLEAR));
      end else begin
        send_item(random_cmd(CMD_TICK));
      end
    end
  endtask

  // Plays one frame with commands and register writes in it that it must ignore.
  task automatic test_frame();
    send_item(pack_cmd(CMD_START, 8'h00, 8'h00, 8'h00, 8'h00));
    repeat (3) send_item(pack_cmd(CMD_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(pack_cmd(CMD_WRITE, 8'd1, 8'h12, 8'h34, 8'h56));
    send_item(pack_cmd(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(pack_cmd(CMD_START, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(pack_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00));
    // Register writes in the middle of a frame must not change it.
    settle();
    write_reg(REG_BRIGHTNESS, 16'd40);
    write_reg(REG_ONE_DUTY, 16'd0);
    write_reg(REG_LATCH, 16'd0);
    end_writes();
    finish_frame(4);
  endtask

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    cmd_i          = '0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_wdata_i    = '0;
    mismatch_count = 0;
    gaps_on        = 1'b1;
    reset_strip_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_reg_writes();
    test_loads(250);
    test_frame();

    settle();
    if (mismatch_count == 0) begin
      $display("led_strip_frame_serializer: match");
    end else begin
      $display("led_strip_frame_serializer: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/lsfs_pkg.sv
hw/rtl/lsfs_color_mem.sv
hw/rtl/led_strip_frame_serializer.sv
tb/sv/tb.sv
